// ===== rtl/core/csplit_pkg.sv =====
package csplit_pkg;

  typedef enum logic [1:0] {
    KindByte    = 2'd0,
    KindEndArg  = 2'd1,
    KindEndLine = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    QuoteNone   = 2'd0,
    QuoteSingle = 2'd1,
    QuoteDouble = 2'd2
  } quote_e;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChBlank  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;

  // up to three results per input byte
  localparam int MaxResults = 3;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } result_t;

  typedef struct packed {
    logic [1:0]                   cnt;
    result_t [MaxResults-1:0]     res;
  } bundle_t;

endpackage

// ===== rtl/core/csplit_front.sv =====
module csplit_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        char_in_i,
  input  logic              line_end_i,
  output logic              stall_o,
  input  logic              full_i,
  output logic              push_o,
  output csplit_pkg::bundle_t bundle_o
);
  import csplit_pkg::*;

  logic   in_arg_q, in_arg_d;
  quote_e quote_q, quote_d;
  logic   esc_q, esc_d;

  logic    accept;
  logic    blank;
  logic    fin;
  logic    mv;
  result_t mres;
  logic    arg_mid;
  quote_e  mine;

  assign stall_o = full_i;
  assign accept  = valid_i && !full_i;
  assign blank   = (char_in_i == ChBlank) || (char_in_i == ChTab);
  assign fin     = (char_in_i == ChNul) || line_end_i;
  assign mine    = (char_in_i == ChSquote) ? QuoteSingle : QuoteDouble;

  // per-byte classification, before any end-of-line handling
  always_comb begin
    arg_mid = in_arg_q;
    quote_d = quote_q;
    esc_d   = esc_q;
    mv      = 1'b0;
    mres    = '{kind: KindByte, ch: char_in_i};
    if (char_in_i != ChNul) begin
      if (esc_q) begin
        esc_d   = 1'b0;
        arg_mid = 1'b1;
        mv      = 1'b1;
      end else if (!in_arg_q && quote_q == QuoteNone && blank) begin
        mv = 1'b0;
      end else begin
        arg_mid = 1'b1;
        if (blank) begin
          mv = 1'b1;
          if (quote_q == QuoteNone) begin
            mres    = '{kind: KindEndArg, ch: ChNul};
            arg_mid = 1'b0;
          end
        end else if (char_in_i == ChSquote || char_in_i == ChDquote) begin
          if (quote_q == QuoteNone) begin
            quote_d = mine;
          end else if (quote_q == mine) begin
            quote_d = QuoteNone;
          end else begin
            mv = 1'b1;
          end
        end else if (char_in_i == ChBslash) begin
          if (quote_q == QuoteSingle) begin
            mv = 1'b1;
          end else begin
            esc_d = 1'b1;
          end
        end else begin
          mv = 1'b1;
        end
      end
    end
  end

  // line end resets all state after closing an open argument
  always_comb begin
    in_arg_d = arg_mid;
    if (fin) begin
      in_arg_d = 1'b0;
    end
  end

  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    bundle_o = '0;
    if (mv) begin
      bundle_o.res[n] = mres;
      n = n + 2'd1;
    end
    if (fin && arg_mid) begin
      bundle_o.res[n] = '{kind: KindEndArg, ch: ChNul};
      n = n + 2'd1;
    end
    if (fin) begin
      bundle_o.res[n] = '{kind: KindEndLine, ch: ChNul};
      n = n + 2'd1;
    end
    bundle_o.cnt = n;
  end

  assign push_o = accept && (bundle_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_arg_q <= 1'b0;
      quote_q  <= QuoteNone;
      esc_q    <= 1'b0;
    end else if (accept) begin
      in_arg_q <= in_arg_d;
      quote_q  <= fin ? QuoteNone : quote_d;
      esc_q    <= fin ? 1'b0 : esc_d;
    end
  end

endmodule

// ===== rtl/core/csplit_fifo.sv =====
module csplit_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  csplit_pkg::bundle_t wdata_i,
  input  logic                pop_i,
  output csplit_pkg::bundle_t rdata_o,
  output logic                full_o,
  output logic                empty_o
);
  import csplit_pkg::*;

  bundle_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wptr_q, rptr_q;
  logic [FifoCntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + FifoPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + FifoCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - FifoCntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/csplit_back.sv =====
module csplit_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csplit_pkg::bundle_t rdata_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                valid_o,
  input  logic                stall_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          char_out_o,
  output logic                last_of_run_o
);
  import csplit_pkg::*;

  logic [1:0] idx_q;
  logic       valid_q;
  result_t    res_q;
  logic       last_q;
  logic       load;
  logic       take;
  logic       is_last;

  assign load    = !valid_q || !stall_i;
  assign take    = load && !empty_i;
  assign is_last = (idx_q == rdata_i.cnt - 2'd1);
  assign pop_o   = take && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= !empty_i;
      end
      if (take) begin
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q  <= rdata_i.res[idx_q];
      last_q <= is_last;
    end
  end

  assign valid_o       = valid_q;
  assign kind_o        = res_q.kind;
  assign char_out_o    = res_q.ch;
  assign last_of_run_o = last_q;

endmodule

// ===== rtl/core/command_argument_splitter.sv =====
// Path: a byte's results are written into the bundle queue, then moved to the
// output register one at a time. Input: one byte per cycle while the queue is not
// full; the output register sends one result per cycle while not stalled, and a
// byte may yield up to three results, so a four-entry bundle queue absorbs the difference.
// Reset: asynchronous, active low; clears parser state, queue and output valid.
module command_argument_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] char_in_i,
  input  logic       line_end_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] char_out_o,
  output logic       last_of_run_o
);
  import csplit_pkg::*;

  bundle_t wbundle, rbundle;
  logic    push, pop, full, empty;

  csplit_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .char_in_i  (char_in_i),
    .line_end_i (line_end_i),
    .stall_o    (stall_o),
    .full_i     (full),
    .push_o     (push),
    .bundle_o   (wbundle)
  );

  csplit_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wbundle),
    .pop_i   (pop),
    .rdata_o (rbundle),
    .full_o  (full),
    .empty_o (empty)
  );

  csplit_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rdata_i       (rbundle),
    .empty_i       (empty),
    .pop_o         (pop),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .kind_o        (kind_o),
    .char_out_o    (char_out_o),
    .last_of_run_o (last_of_run_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && empty))
    else $error("queue read while empty");

  a_eol_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && kind_o == KindEndLine) |-> last_of_run_o)
    else $error("end of line not last result of its byte");

  a_mark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && kind_o != KindByte) |-> (char_out_o == ChNul))
    else $error("mark carries nonzero byte");

endmodule

// ===== test/command_argument_splitter_tb.sv =====
`timescale 1ns / 100ps

module command_argument_splitter_tb;
  import csplit_pkg::*;

  typedef struct {
    kind_e      kind;
    logic [7:0] ch;
    logic       last;
  } token_t;

  class arg_split_scoreboard;
    bit         in_arg;
    quote_e     qmode;
    bit         esc_pend;
    token_t     expected_tokens[$];
    int         errors;

    function new();
      in_arg   = 1'b0;
      qmode    = QuoteNone;
      esc_pend = 1'b0;
      errors   = 0;
    endfunction

    function void emit_token(kind_e k, logic [7:0] c);
      token_t t;
      t.kind = k;
      t.ch   = c;
      t.last = 1'b0;
      expected_tokens.push_back(t);
    endfunction

    function void close_line();
      if (in_arg) emit_token(KindEndArg, 8'h00);
      emit_token(KindEndLine, 8'h00);
      in_arg   = 1'b0;
      qmode    = QuoteNone;
      esc_pend = 1'b0;
    endfunction

    // predict the tokens caused by one accepted input transfer
    function void note_byte(logic [7:0] c, logic le);
      bit     blank;
      int     n0;
      quote_e mine;
      blank = (c == ChBlank) || (c == ChTab);
      n0    = expected_tokens.size();
      if (c == ChNul) begin
        close_line();
      end else begin
        if (esc_pend) begin
          esc_pend = 1'b0;
          in_arg   = 1'b1;
          emit_token(KindByte, c);
        end else if (!in_arg && qmode == QuoteNone && blank) begin
          // separator between arguments
        end else begin
          in_arg = 1'b1;
          if (blank) begin
            if (qmode != QuoteNone) begin
              emit_token(KindByte, c);
            end else begin
              emit_token(KindEndArg, 8'h00);
              in_arg = 1'b0;
            end
          end else if (c == ChSquote || c == ChDquote) begin
            if (c == ChSquote) mine = QuoteSingle;
            else mine = QuoteDouble;
            if (qmode == QuoteNone) qmode = mine;
            else if (qmode == mine) qmode = QuoteNone;
            else emit_token(KindByte, c);
          end else if (c == ChBslash) begin
            if (qmode == QuoteSingle) emit_token(KindByte, c);
            else esc_pend = 1'b1;
          end else begin
            emit_token(KindByte, c);
          end
        end
        if (le) close_line();
      end
      if (expected_tokens.size() > n0)
        expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    function void check_token(logic [1:0] kind, logic [7:0] ch, logic last);
      token_t t;
      if (expected_tokens.size() == 0) begin
        $error("unexpected output transfer: kind %0d char %0h last %0b", kind, ch, last);
        errors++;
      end else begin
        t = expected_tokens.pop_front();
        if (kind !== t.kind) begin
          $error("kind mismatch: expected %0d, got %0d", t.kind, kind);
          errors++;
        end
        if (ch !== t.ch) begin
          $error("char_out mismatch: expected %0h, got %0h", t.ch, ch);
          errors++;
        end
        if (last !== t.last) begin
          $error("last_of_run mismatch: expected %0b, got %0b", t.last, last);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction
  endclass

  localparam int LongHold  = 80;
  localparam int IdleLimit = 2000;

  logic       clk_i;
  logic       rst_ni;
  logic       valid_i;
  logic       stall_o;
  logic [7:0] char_in_i;
  logic       line_end_i;
  logic       valid_o;
  logic       stall_i;
  logic [1:0] kind_o;
  logic [7:0] char_out_o;
  logic       last_of_run_o;

  arg_split_scoreboard sb;
  int  bytes_sent;
  int  idle_cycles;
  bit  tx_idle_on;
  bit  rx_idle_on;
  bit  hold_req;

  command_argument_splitter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .char_in_i    (char_in_i),
    .line_end_i   (line_end_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .kind_o       (kind_o),
    .char_out_o   (char_out_o),
    .last_of_run_o(last_of_run_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) sb.note_byte(char_in_i, line_end_i);
      if (valid_o && !stall_i) sb.check_token(kind_o, char_out_o, last_of_run_o);
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int burst_left;
    int long_left;
    burst_left = 0;
    long_left  = 0;
    stall_i    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_left > 0) begin
        stall_i <= 1'b1;
        long_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        long_left = LongHold - 1;
        stall_i <= 1'b1;
      end else if (burst_left > 0) begin
        stall_i <= 1'b1;
        burst_left--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 5);
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] c, input logic le);
    int gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i    <= 1'b1;
    char_in_i  <= c;
    line_end_i <= le;
    do @(posedge clk_i); while (stall_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_str(input string s, input logic le_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], le_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 11))
      0, 1:    return ChBlank;
      2:       return ChTab;
      3:       return ChSquote;
      4:       return ChDquote;
      5:       return ChBslash;
      6:       return 8'($urandom_range(1, 255));
      default: return 8'($urandom_range(8'h61, 8'h7a));
    endcase
  endfunction

  // mostly well-formed lines of random content, some raw noise bytes
  task automatic send_random_line();
    int len;
    int ending;
    if ($urandom_range(0, 7) == 0) begin
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      len    = $urandom_range(1, 10);
      ending = $urandom_range(0, 3);
      for (int i = 0; i < len; i++)
        send_byte(pick_char(), (ending < 2) && (i == len - 1));
      if (ending == 2) send_byte(ChNul, 1'b0);
      else if (ending == 3) send_byte(ChNul, 1'b1);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    sb          = new();
    bytes_sent  = 0;
    idle_cycles = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    hold_req    = 1'b0;
    rst_ni      = 1'b0;
    valid_i     = 1'b0;
    char_in_i   = 8'h00;
    line_end_i  = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed lines
    send_str(" a", 1'b1);                 // leading blank skipped
    send_str("''", 1'b1);                 // empty quotes still give an argument
    send_str("\"'\\", 1'b0);              // open double quote, final backslash
    send_byte(ChNul, 1'b0);
    send_str("'\\\"'", 1'b1);             // backslash kept inside single quotes
    send_str("\\ \\", 1'b0);              // escaped blank, escaped 0xff
    send_byte(8'hFF, 1'b0);
    send_byte(ChBlank, 1'b0);             // trailing blank
    send_byte(ChNul, 1'b0);
    send_byte(ChNul, 1'b1);               // zero byte with line end flag
    send_byte(ChNul, 1'b0);               // empty line
    send_byte(8'h01, 1'b1);
    send_str("a\t b", 1'b1);
    send_str("\\", 1'b1);                 // backslash flagged as last byte

    while (bytes_sent < 80) send_random_line();

    // long receiver hold-off while the sender keeps pushing
    tx_idle_on = 1'b0;
    hold_req   = 1'b1;
    while (bytes_sent < 105) send_random_line();
    tx_idle_on = 1'b1;

    valid_i <= 1'b0;
    wait_drained();

    while (bytes_sent < 170) send_random_line();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (bytes_sent < 222) send_random_line();

    valid_i <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
